### sv/gne_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types and constants for the grid neighbour enumerator.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int MAX_NEIGHBORS_DEF = 32;
    localparam int INDEX_BITS_DEF    = 48;
    localparam int DIM_BITS_DEF      = 16;

    localparam int SLOT_BITS   = 5;
    localparam int DELTA_BITS  = 8;
    localparam int COUNT_BITS  = 6;
    localparam int COORD_Z_BITS = 32;
    localparam int ENTRY_BITS  = 3 * DELTA_BITS;

    // APB register map, byte addresses
    localparam int PADDR_BITS = 4;
    localparam logic [PADDR_BITS-1:0] ADDR_DIM_X = 4'h0;
    localparam logic [PADDR_BITS-1:0] ADDR_DIM_Y = 4'h4;
    localparam logic [PADDR_BITS-1:0] ADDR_DIM_Z = 4'h8;
    localparam logic [PADDR_BITS-1:0] ADDR_COUNT = 4'hC;

    // input command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;   // write a table slot from the input transaction
        logic start;     // capture origin, start x division
        logic div2;      // capture x, start y/z division
        logic coords;    // capture y and z, reset the walk
        logic rd;        // read current table slot
        logic chk;       // bounds test and offset products
        logic keep;      // slot kept: push held result, hold the new one
        logic advance;   // next slot
        logic finish;    // emit final result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic walk_end;
        logic inb;
        logic held_valid;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

### sv/gne_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_in_if / gne_out_if
// Valid/ready channels carrying command and result transactions.
// ----------------------------------------------------------------------------
interface gne_in_if #(
    parameter int INDEX_BITS = 48
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [4:0]            slot;
    logic signed [7:0]     delta_x;
    logic signed [7:0]     delta_y;
    logic signed [7:0]     delta_z;
    logic [INDEX_BITS-1:0] origin_index;

    modport source (output valid, cmd, slot, delta_x, delta_y, delta_z, origin_index,
                    input ready);
    modport sink   (input valid, cmd, slot, delta_x, delta_y, delta_z, origin_index,
                    output ready);
endinterface

interface gne_out_if #(
    parameter int INDEX_BITS = 48
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] neighbor_index;
    logic [4:0]            neighbor_slot;
    logic                  none_inside;
    logic                  last;

    modport source (output valid, neighbor_index, neighbor_slot, none_inside, last,
                    input ready);
    modport sink   (input valid, neighbor_index, neighbor_slot, none_inside, last,
                    output ready);
endinterface
`default_nettype wire

### sv/grid_neighbor_enumerator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_neighbor_enumerator_unit
// Stencil neighbour enumerator for a regular 3D grid.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0) writes one slot of the delta table. A query
// transaction (cmd 1) splits the origin index into x, y, z with two passes
// through one shared restoring divider, then walks slots
// 0 .. min(neighbor_count, MAX_NEIGHBORS)-1, each with a table read, a bounds
// test with offset products and an index sum, and closes with the end-of-walk
// test and the final result. A kept neighbour may wait for the output
// register. Results are emitted in slot order; the last carries last=1.
// If nothing lies inside the grid a single result with none_inside=1 is given.
// The input is taken only while the sequencer is idle; the output register
// lets the last result wait while the next transaction is taken. The table has
// no reset: querying a slot never loaded gives undefined results. Registers:
// dim_x at 0x0, dim_y at 0x4, dim_z at 0x8, neighbor_count at 0xC.
// ----------------------------------------------------------------------------
module grid_neighbor_enumerator_unit
    import gne_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int DIM_BITS      = DIM_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // transaction channels
    gne_in_if.sink                     i_in,
    gne_out_if.source                  o_out
);
    // configuration registers
    logic [DIM_BITS-1:0]   r_dim_x;
    logic [DIM_BITS-1:0]   r_dim_y;
    logic [DIM_BITS-1:0]   r_dim_z;
    logic [COUNT_BITS-1:0] r_count;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_BITS'(1);
            r_dim_y <= DIM_BITS'(1);
            r_dim_z <= DIM_BITS'(1);
            r_count <= '0;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_DIM_X: r_dim_x <= pwdata[DIM_BITS-1:0];
                ADDR_DIM_Y: r_dim_y <= pwdata[DIM_BITS-1:0];
                ADDR_DIM_Z: r_dim_z <= pwdata[DIM_BITS-1:0];
                ADDR_COUNT: r_count <= pwdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_DIM_X: prdata = 32'(r_dim_x);
            ADDR_DIM_Y: prdata = 32'(r_dim_y);
            ADDR_DIM_Z: prdata = 32'(r_dim_z);
            ADDR_COUNT: prdata = 32'(r_count);
            default:    prdata = '0;
        endcase
    end

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    gne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    gne_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .INDEX_BITS    (INDEX_BITS),
        .DIM_BITS      (DIM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_dim_x     (r_dim_x),
        .i_dim_y     (r_dim_y),
        .i_dim_z     (r_dim_z),
        .i_count     (r_count),
        .i_slot      (i_in.slot),
        .i_dx        (i_in.delta_x),
        .i_dy        (i_in.delta_y),
        .i_dz        (i_in.delta_z),
        .i_origin    (i_in.origin_index),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_index (o_out.neighbor_index),
        .o_out_slot  (o_out.neighbor_slot),
        .o_out_none  (o_out.none_inside),
        .o_out_last  (o_out.last)
    );
endmodule
`default_nettype wire

### sv/gne_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gne_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### sv/gne_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gne_div #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,   // never zero
    output logic                     o_busy,
    output logic      [NUM_BITS-1:0] o_quot,
    output logic      [DEN_BITS-1:0] o_rem
);
    localparam int CW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    assign trial = {r_rem, r_q[NUM_BITS-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CW'(NUM_BITS - 1);
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_BITS-2:0], ge};
            r_rem <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

### sv/gne_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_ctrl
// Sequencer: command decode, the two divisions, and the slot walk.
// ----------------------------------------------------------------------------
module gne_ctrl
    import gne_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_cmd,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div2 = 1'b1;
                    n_state    = S_DIV2;
                end
            end
            S_DIV2: begin
                if (!i_sts.div_busy) begin
                    o_cmd.coords = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.walk_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                if (!i_sts.inb) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end else if (!i_sts.held_valid || i_sts.out_free) begin
                    o_cmd.keep    = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### sv/gne_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_dp
// Datapath: delta table, coordinate split, bounds test, index sum, output.
// ----------------------------------------------------------------------------
module gne_dp
    import gne_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int DIM_BITS      = DIM_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_sts                              o_sts,
    input  wire logic [DIM_BITS-1:0]          i_dim_x,
    input  wire logic [DIM_BITS-1:0]          i_dim_y,
    input  wire logic [DIM_BITS-1:0]          i_dim_z,
    input  wire logic [COUNT_BITS-1:0]        i_count,
    input  wire logic [SLOT_BITS-1:0]         i_slot,
    input  wire logic signed [DELTA_BITS-1:0] i_dx,
    input  wire logic signed [DELTA_BITS-1:0] i_dy,
    input  wire logic signed [DELTA_BITS-1:0] i_dz,
    input  wire logic [INDEX_BITS-1:0]        i_origin,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [INDEX_BITS-1:0]             o_out_index,
    output logic [SLOT_BITS-1:0]              o_out_slot,
    output logic                              o_out_none,
    output logic                              o_out_last
);
    localparam int AW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int PZW = DELTA_BITS + 2 * DIM_BITS + 1;
    localparam int PYW = DELTA_BITS + DIM_BITS + 1;
    localparam int SW  = (INDEX_BITS > PZW) ? INDEX_BITS : PZW;
    localparam int ZW  = COORD_Z_BITS;

    // division unit
    logic                  div_busy;
    logic [INDEX_BITS-1:0] div_quot;
    logic [DIM_BITS-1:0]   div_rem;
    logic [DIM_BITS-1:0]   dx_eff;
    logic [DIM_BITS-1:0]   dy_eff;

    assign dx_eff = (i_dim_x == '0) ? DIM_BITS'(1) : i_dim_x;
    assign dy_eff = (i_dim_y == '0) ? DIM_BITS'(1) : i_dim_y;

    gne_div #(
        .NUM_BITS (INDEX_BITS),
        .DEN_BITS (DIM_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start | i_cmd.div2),
        .i_num   (i_cmd.div2 ? div_quot : i_origin),
        .i_den   (i_cmd.div2 ? dy_eff : dx_eff),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // delta table
    logic [ENTRY_BITS-1:0] rd_entry;
    logic [CW-1:0]         r_walk;

    gne_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_NEIGHBORS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && (int'(i_slot) < MAX_NEIGHBORS)),
        .i_waddr (AW'(i_slot)),
        .i_wdata ({i_dz, i_dy, i_dx}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_walk[AW-1:0]),
        .o_rdata (rd_entry)
    );

    // query state
    logic [INDEX_BITS-1:0]   r_origin;
    logic [2*DIM_BITS-1:0]   r_dxy;
    logic [DIM_BITS-1:0]     r_cx;
    logic [DIM_BITS-1:0]     r_cy;
    logic [ZW-1:0]           r_cz;
    logic [ZW+INDEX_BITS-1:0] z_ext;
    logic [CW-1:0]           n_eff;

    assign z_ext = {ZW'(0), div_quot};
    assign n_eff = (int'(i_count) > MAX_NEIGHBORS) ? CW'(MAX_NEIGHBORS) : CW'(i_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_origin <= i_origin;
            r_dxy    <= i_dim_x * i_dim_y;
        end
        if (i_cmd.div2) begin
            r_cx <= div_rem;
        end
        if (i_cmd.coords) begin
            r_cy <= div_rem;
            r_cz <= (|z_ext[ZW+INDEX_BITS-1:ZW]) ? '1 : z_ext[ZW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coords) begin
            r_walk <= '0;
        end else if (i_cmd.advance) begin
            r_walk <= r_walk + 1'b1;
        end
    end

    // bounds test and offset products
    logic signed [DELTA_BITS-1:0] e_dx, e_dy, e_dz;
    logic signed [DIM_BITS+1:0]   px, py;
    logic signed [ZW+1:0]         pz;
    logic                         ok;
    logic                         r_inb;
    logic signed [PZW-1:0]        r_pz;
    logic signed [PYW-1:0]        r_py;
    logic signed [DELTA_BITS-1:0] r_dx;

    assign e_dx = rd_entry[DELTA_BITS-1:0];
    assign e_dy = rd_entry[2*DELTA_BITS-1:DELTA_BITS];
    assign e_dz = rd_entry[3*DELTA_BITS-1:2*DELTA_BITS];
    assign px = $signed({2'b00, r_cx}) + (DIM_BITS+2)'(e_dx);
    assign py = $signed({2'b00, r_cy}) + (DIM_BITS+2)'(e_dy);
    assign pz = $signed({2'b00, r_cz}) + (ZW+2)'(e_dz);
    assign ok = !px[DIM_BITS+1] && (px[DIM_BITS:0] < {1'b0, i_dim_x})
             && !py[DIM_BITS+1] && (py[DIM_BITS:0] < {1'b0, i_dim_y})
             && !pz[ZW+1] && (pz[ZW:0] < (ZW+1)'(i_dim_z));

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_inb <= ok;
            r_pz  <= e_dz * $signed({1'b0, r_dxy});
            r_py  <= e_dy * $signed({1'b0, i_dim_x});
            r_dx  <= e_dx;
        end
    end

    logic [SW-1:0] sum;
    assign sum = SW'(r_origin) + SW'(r_pz) + SW'(r_py) + SW'(r_dx);

    // held result and output register
    logic                  r_held_valid;
    logic [INDEX_BITS-1:0] r_held_index;
    logic [SLOT_BITS-1:0]  r_held_slot;
    logic                  r_out_valid;
    logic                  out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (i_cmd.coords || i_cmd.finish) begin
            r_held_valid <= 1'b0;
        end else if (i_cmd.keep) begin
            r_held_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.keep) begin
            r_held_index <= sum[INDEX_BITS-1:0];
            r_held_slot  <= SLOT_BITS'(r_walk);
        end
    end

    logic push;
    assign push = (i_cmd.keep && r_held_valid) || i_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            o_out_index <= (i_cmd.finish && !r_held_valid) ? '0 : r_held_index;
            o_out_slot  <= (i_cmd.finish && !r_held_valid) ? '0 : r_held_slot;
            o_out_none  <= i_cmd.finish && !r_held_valid;
            o_out_last  <= i_cmd.finish;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sts.div_busy   = div_busy;
    assign o_sts.walk_end   = r_walk >= n_eff;
    assign o_sts.inb        = r_inb;
    assign o_sts.held_valid = r_held_valid;
    assign o_sts.out_free   = out_free;
endmodule
`default_nettype wire

### sv/gne_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gne_chk
// Port-level checks for the grid neighbour enumerator.
// ----------------------------------------------------------------------------
module gne_chk #(
    parameter int INDEX_BITS = 48
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [INDEX_BITS-1:0] i_out_index,
    input wire logic [4:0]            i_out_slot,
    input wire logic                  i_out_none,
    input wire logic                  i_out_last
);
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_index) && $stable(i_out_slot))
        else $error("stalled result changed");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_none |-> i_out_last)
        else $error("none result without last");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_none |-> i_out_index == '0 && i_out_slot == '0)
        else $error("none result carries an index");
endmodule

bind grid_neighbor_enumerator_unit gne_chk #(
    .INDEX_BITS (INDEX_BITS)
) u_gne_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.neighbor_index),
    .i_out_slot  (o_out.neighbor_slot),
    .i_out_none  (o_out.none_inside),
    .i_out_last  (o_out.last)
);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_neighbor_enumerator_unit: loads stencil tables,
// runs origin queries over several grid shapes and compares every neighbour
// result against an in-bench predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import gne_pkg::*;

    localparam int IB        = INDEX_BITS_DEF;
    localparam int NSLOT     = MAX_NEIGHBORS_DEF;
    localparam int CYC_LIMIT = 1000000;

    typedef struct packed {
        logic [IB-1:0]        idx;
        logic [SLOT_BITS-1:0] slot;
        logic                 none;
        logic                 last;
    } t_nbr;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gne_in_if  #(.INDEX_BITS(IB)) cmd_ch ();
    gne_out_if #(.INDEX_BITS(IB)) nbr_ch ();

    grid_neighbor_enumerator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in(cmd_ch.sink), .o_out(nbr_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: grid shape, stencil size, delta table and what is loaded
    logic [15:0] g_dx = 16'd1, g_dy = 16'd1, g_dz = 16'd1;
    logic [COUNT_BITS-1:0] g_cnt = '0;
    logic signed [7:0] tab_x [NSLOT];
    logic signed [7:0] tab_y [NSLOT];
    logic signed [7:0] tab_z [NSLOT];
    bit loaded [NSLOT];

    t_nbr expected_nbrs [$];
    int   mismatches = 0;
    int   n_results  = 0;
    int   n_none     = 0;
    int   n_queries  = 0;
    int   cycles     = 0;
    bit   stall_en   = 1'b1;
    bit   out_stall_en = 1'b1;

    initial begin
        cmd_ch.valid = 1'b0; cmd_ch.cmd = CMD_LOAD; cmd_ch.slot = '0;
        cmd_ch.delta_x = '0; cmd_ch.delta_y = '0; cmd_ch.delta_z = '0;
        cmd_ch.origin_index = '0;
        nbr_ch.ready = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_nbrs.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit axis_in(logic [31:0] c, logic signed [7:0] d, logic [15:0] dim);
        longint p;
        p = longint'(c) + longint'(d);
        return (p >= 0) && (p < longint'(dim));
    endfunction

    // splits the origin into coordinates and queues every in-grid neighbour, or a none result
    task automatic predict_neighbours(logic [IB-1:0] v);
        longint unsigned ux, uy, zq;
        logic [31:0] cx, cy, cz;
        logic [IB-1:0] ofs;
        int n, kept;
        t_nbr r;
        ux = (g_dx == 0) ? 1 : g_dx;
        uy = (g_dy == 0) ? 1 : g_dy;
        cx = v % ux;
        cy = (v / ux) % uy;
        zq = v / (ux * uy);
        cz = (zq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zq[31:0];
        n = (g_cnt > NSLOT) ? NSLOT : g_cnt;
        kept = 0;
        for (int s = 0; s < n; s++) begin
            if (axis_in(cx, tab_x[s], g_dx) && axis_in(cy, tab_y[s], g_dy) &&
                axis_in(cz, tab_z[s], g_dz)) begin
                ofs = IB'(longint'(tab_z[s]) * longint'(g_dx) * longint'(g_dy)
                        + longint'(tab_y[s]) * longint'(g_dx) + longint'(tab_x[s]));
                r.idx = v + ofs; r.slot = s[4:0]; r.none = 1'b0; r.last = 1'b0;
                expected_nbrs.push_back(r);
                kept++;
            end
        end
        if (kept == 0) begin
            r = '0; r.none = 1'b1; r.last = 1'b1;
            expected_nbrs.push_back(r);
        end else begin
            expected_nbrs[expected_nbrs.size()-1].last = 1'b1;
        end
    endtask

    // one command transaction; predictor updated at acceptance. valid stays
    // up afterwards so that the next call can follow with no gap
    task automatic send_cmd(logic c, logic [4:0] sl, logic [7:0] ddx, logic [7:0] ddy,
                            logic [7:0] ddz, logic [IB-1:0] org);
        int gap;
        if (stall_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.cmd          <= c;
        cmd_ch.slot         <= sl;
        cmd_ch.delta_x      <= ddx;
        cmd_ch.delta_y      <= ddy;
        cmd_ch.delta_z      <= ddz;
        cmd_ch.origin_index <= org;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (c == CMD_LOAD) begin
            tab_x[sl] = ddx; tab_y[sl] = ddy; tab_z[sl] = ddz; loaded[sl] = 1'b1;
        end else begin
            predict_neighbours(org);
            n_queries++;
        end
    endtask

    task automatic load_slot(int s);
        send_cmd(CMD_LOAD, s[4:0], 8'($urandom), 8'($urandom), 8'($urandom), IB'($urandom));
    endtask

    task automatic query(logic [IB-1:0] org);
        send_cmd(CMD_QUERY, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), org);
    endtask

    // APB write: setup then access cycle
    task automatic reg_write(logic [PADDR_BITS-1:0] a, logic [31:0] d);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            ADDR_DIM_X: g_dx  = d[15:0];
            ADDR_DIM_Y: g_dy  = d[15:0];
            ADDR_DIM_Z: g_dz  = d[15:0];
            ADDR_COUNT: g_cnt = d[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // drops valid, then waits for all expected results plus the drain time
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (expected_nbrs.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic set_grid(int x, int y, int z, int c);
        drain();
        reg_write(ADDR_DIM_X, 32'(x));
        reg_write(ADDR_DIM_Y, 32'(y));
        reg_write(ADDR_DIM_Z, 32'(z));
        reg_write(ADDR_COUNT, 32'(c));
    endtask

    // a random origin, mostly inside the grid
    function automatic logic [IB-1:0] pick_origin();
        longint unsigned tot;
        tot = longint'(g_dx) * longint'(g_dy) * longint'(g_dz);
        if ($urandom_range(0, 9) == 0 || tot == 0)
            return {16'($urandom), 32'($urandom)};
        return IB'({32'($urandom), 32'($urandom)} % tot);
    endfunction

    // result checker with random back-pressure
    initial begin
        int hold;
        t_nbr exp_r;
        @(posedge i_rst_n);
        forever begin
            if (out_stall_en && $urandom_range(0, 3) == 0) begin
                nbr_ch.ready <= 1'b0;
                hold = $urandom_range(1, 10);
                repeat (hold) @(posedge i_clk);
            end
            nbr_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (nbr_ch.valid && nbr_ch.ready) begin
                n_results++;
                if (expected_nbrs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result idx=%0h slot=%0d",
                                 nbr_ch.neighbor_index, nbr_ch.neighbor_slot);
                end else begin
                    exp_r = expected_nbrs.pop_front();
                    if (exp_r.none) n_none++;
                    if (nbr_ch.neighbor_index !== exp_r.idx ||
                        nbr_ch.neighbor_slot !== exp_r.slot ||
                        nbr_ch.none_inside !== exp_r.none || nbr_ch.last !== exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp idx=%0h slot=%0d none=%b last=%b,",
                                     exp_r.idx, exp_r.slot, exp_r.none, exp_r.last);
                            $display("          got idx=%0h slot=%0d none=%b last=%b",
                                     nbr_ch.neighbor_index, nbr_ch.neighbor_slot,
                                     nbr_ch.none_inside, nbr_ch.last);
                        end
                    end
                end
            end
        end
    end

    // 6-point face stencil in slots 0..5, extreme deltas in slots 6 and 7, others random
    task automatic test_directed();
        send_cmd(CMD_LOAD, 5'd0, 8'sd1,  8'sd0,  8'sd0, '1);
        send_cmd(CMD_LOAD, 5'd1, -8'sd1, 8'sd0,  8'sd0, '0);
        send_cmd(CMD_LOAD, 5'd2, 8'sd0,  8'sd1,  8'sd0, '0);
        send_cmd(CMD_LOAD, 5'd3, 8'sd0,  -8'sd1, 8'sd0, '0);
        send_cmd(CMD_LOAD, 5'd4, 8'sd0,  8'sd0,  8'sd1, '0);
        send_cmd(CMD_LOAD, 5'd5, 8'sd0,  8'sd0,  -8'sd1, '0);
        send_cmd(CMD_LOAD, 5'd6, 8'h7F, 8'h80, 8'h7F, '0);
        send_cmd(CMD_LOAD, 5'd7, 8'h80, 8'h7F, 8'h80, '0);
        for (int s = 8; s < NSLOT; s++) load_slot(s);
        // reset shape 1x1x1 with no slots
        query('0);
        set_grid(4, 4, 4, 6);
        query(IB'(0)); query(IB'(21)); query(IB'(63)); query(IB'(64)); query('1);
        set_grid(0, 4, 4, 6);
        query(IB'(5));
        set_grid(65535, 65535, 65535, 8);
        query('1); query(IB'(65535)); query(IB'(48'h0000_8000_8000));
        set_grid(200, 200, 200, 63);
        query(IB'(4_020_100)); query(IB'(0));
        set_grid(1, 1, 1, 0);
        query(IB'(0));
    endtask

    task automatic test_random();
        int shape;
        for (int ph = 0; ph < 8; ph++) begin
            shape = $urandom_range(0, 3);
            case (shape)
                0: set_grid($urandom_range(1, 8), $urandom_range(1, 8),
                            $urandom_range(1, 8), $urandom_range(0, 32));
                1: set_grid($urandom_range(1, 300), $urandom_range(1, 300),
                            $urandom_range(1, 300), $urandom_range(1, 63));
                2: set_grid($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 63));
                default: set_grid($urandom_range(3, 20), $urandom_range(3, 20),
                                  $urandom_range(0, 3), $urandom_range(4, 16));
            endcase
            if (ph == 7) begin
                stall_en = 1'b0;
                out_stall_en = 1'b0;
            end
            for (int i = 0; i < 20; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // small deltas keep many neighbours inside the grid
                    send_cmd(CMD_LOAD, 5'($urandom), 8'($urandom_range(0, 4) - 2),
                             8'($urandom_range(0, 4) - 2), 8'($urandom_range(0, 4) - 2),
                             IB'($urandom));
                end else begin
                    query(pick_origin());
                end
            end
        end
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            tab_x[s] = '0; tab_y[s] = '0; tab_z[s] = '0; loaded[s] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain();
        $display("covered %0d queries, %0d results (%0d with no neighbour inside)",
                 n_queries, n_results, n_none);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end
endmodule
